/* design/mhpq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int DEFAULT_HEAP_DEPTH = 1024;
  localparam int VAL_W = 32;
  localparam int COUNT_OUT_W = 11;
  localparam int STATUS_W = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic ld_ins;
    logic ld_del;
    logic rej_full;
    logic rej_empty;
    logic up_rd;
    logic up_move;
    logic up_place;
    logic dn_key;
    logic dn_rd;
    logic dn_move;
    logic dn_place;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic parent_less;
    logic has_child;
    logic child_greater;
    logic count_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* design/mhpq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          req_type,
  input  wire mhpq_pkg::stat_t st,
  output mhpq_pkg::cmd_t     cmd
);
  import mhpq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_UP_RD     = 7'b0000010,
    S_UP_CMP    = 7'b0000100,
    S_LAST_WAIT = 7'b0001000,
    S_DN_RD     = 7'b0010000,
    S_DN_CMP    = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_INSERT) begin
            if (st.full) begin
              cmd.rej_full = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.ld_ins = 1'b1;
              state_next = S_UP_RD;
            end
          end else begin
            if (st.empty) begin
              cmd.rej_empty = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.ld_del = 1'b1;
              state_next = S_LAST_WAIT;
            end
          end
        end
      end
      S_UP_RD: begin
        if (st.at_root) begin
          cmd.up_place = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.up_rd = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.parent_less) begin
          cmd.up_move = 1'b1;
          state_next = S_UP_RD;
        end else begin
          cmd.up_place = 1'b1;
          state_next = S_DONE;
        end
      end
      S_LAST_WAIT: begin
        if (st.count_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.dn_key = 1'b1;
          state_next = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (st.has_child) begin
          cmd.dn_rd = 1'b1;
          state_next = S_DN_CMP;
        end else begin
          cmd.dn_place = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DN_CMP: begin
        if (st.child_greater) begin
          cmd.dn_move = 1'b1;
          state_next = S_DN_RD;
        end else begin
          cmd.dn_place = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/mhpq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module mhpq_dp #(
  parameter int HEAP_DEPTH = mhpq_pkg::DEFAULT_HEAP_DEPTH
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire mhpq_pkg::cmd_t                             cmd,
  output mhpq_pkg::stat_t                                 st,
  input  wire logic signed [mhpq_pkg::VAL_W-1:0]          item_value,
  output logic                                            out_valid,
  input  wire logic                                       out_stall,
  output logic signed [mhpq_pkg::VAL_W-1:0]               removed_value,
  output logic signed [mhpq_pkg::VAL_W-1:0]               top_value,
  output logic [mhpq_pkg::COUNT_OUT_W-1:0]                entry_count,
  output logic [mhpq_pkg::STATUS_W-1:0]                   status
);
  import mhpq_pkg::*;

  localparam int P_W = $clog2(HEAP_DEPTH + 1);
  localparam int ADDR_W = $clog2(HEAP_DEPTH);

  logic [VAL_W-1:0] mem [HEAP_DEPTH];

  logic [P_W-1:0] count;
  logic [P_W-1:0] pos;
  logic signed [VAL_W-1:0] key;
  logic signed [VAL_W-1:0] top;
  logic signed [VAL_W-1:0] removed;
  logic [STATUS_W-1:0] op_status;
  logic signed [VAL_W-1:0] rd_a;
  logic signed [VAL_W-1:0] rd_b;

  logic [P_W:0] left_pos;
  logic [P_W:0] right_pos;
  logic [P_W:0] count_w;
  logic [P_W-1:0] pos_m1;
  logic [P_W-1:0] count_m1;
  logic [P_W-1:0] parent_m1;
  logic [ADDR_W-1:0] ra_addr;
  logic [ADDR_W-1:0] rb_addr;
  logic sel_right;
  logic signed [VAL_W-1:0] child_val;
  logic [P_W:0] child_pos;
  logic wr_en;
  logic signed [VAL_W-1:0] wr_data;
  logic [P_W+COUNT_OUT_W-1:0] count_ext;

  assign left_pos = {pos, 1'b0};
  assign right_pos = left_pos + 1'b1;
  assign count_w = {1'b0, count};
  assign pos_m1 = pos - 1'b1;
  assign count_m1 = count - 1'b1;
  assign parent_m1 = (pos >> 1) - 1'b1;
  assign sel_right = (right_pos <= count_w) && (rd_b > rd_a);
  assign child_val = sel_right ? rd_b : rd_a;
  assign child_pos = sel_right ? right_pos : left_pos;

  always_comb begin
    ra_addr = left_pos[ADDR_W-1:0] - 1'b1;
    if (cmd.ld_del) begin
      ra_addr = count_m1[ADDR_W-1:0];
    end else if (cmd.up_rd) begin
      ra_addr = parent_m1[ADDR_W-1:0];
    end
  end

  assign rb_addr = left_pos[ADDR_W-1:0];

  assign wr_en = cmd.up_move | cmd.up_place | cmd.dn_move | cmd.dn_place;

  always_comb begin
    wr_data = key;
    if (cmd.up_move) begin
      wr_data = rd_a;
    end else if (cmd.dn_move) begin
      wr_data = child_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_m1[ADDR_W-1:0]] <= wr_data;
    end
    rd_a <= mem[ra_addr];
    if (cmd.dn_rd) begin
      rd_b <= mem[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ld_ins) begin
      count <= count + 1'b1;
    end else if (cmd.ld_del) begin
      count <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_ins) begin
      pos <= count + 1'b1;
      key <= item_value;
    end else if (cmd.dn_key) begin
      pos <= P_W'(1);
      key <= rd_a;
    end else if (cmd.up_move) begin
      pos <= pos >> 1;
    end else if (cmd.dn_move) begin
      pos <= child_pos[P_W-1:0];
    end
    if (wr_en && pos == P_W'(1)) begin
      top <= wr_data;
    end
    if (cmd.ld_ins || cmd.rej_full || cmd.rej_empty) begin
      removed <= '0;
    end else if (cmd.ld_del) begin
      removed <= top;
    end
    if (cmd.ld_ins || cmd.ld_del) begin
      op_status <= ST_OK;
    end else if (cmd.rej_full) begin
      op_status <= ST_FULL;
    end else if (cmd.rej_empty) begin
      op_status <= ST_EMPTY;
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      removed_value <= removed;
      top_value <= (count != '0) ? top : '0;
      entry_count <= count_ext[COUNT_OUT_W-1:0];
      status <= op_status;
    end
  end

  always_comb begin
    st.full = (count == P_W'(HEAP_DEPTH));
    st.empty = (count == '0);
    st.at_root = (pos == P_W'(1));
    st.parent_less = (rd_a < key);
    st.has_child = (left_pos <= count_w);
    st.child_greater = (child_val > key);
    st.count_zero = (count == '0);
    st.out_free = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

/* design/max_heap_priority_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Fields
// in       in_valid, in_stall   req_type, item_value
// out      out_valid, out_stall removed_value, top_value, entry_count, status
//
// One item is worked on at a time; in_stall is low only while the block is idle.
// An insert moves each smaller parent down until the root or a parent at least as large.
// A delete moves the last entry to the root and sinks it past each larger child, unless
// it empties the heap; a refused item goes straight to the output register.
// Reset empties the heap at once; the store itself is not cleared.
// A finished result waits in the output register while out_stall is high.

module max_heap_priority_queue #(
  parameter int HEAP_DEPTH = mhpq_pkg::DEFAULT_HEAP_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 req_type,
  input  wire logic signed [mhpq_pkg::VAL_W-1:0]    item_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [mhpq_pkg::VAL_W-1:0]         removed_value,
  output logic signed [mhpq_pkg::VAL_W-1:0]         top_value,
  output logic [mhpq_pkg::COUNT_OUT_W-1:0]          entry_count,
  output logic [mhpq_pkg::STATUS_W-1:0]             status
);
  import mhpq_pkg::*;

  cmd_t  cmd;
  stat_t st;

  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .st       (st),
    .cmd      (cmd)
  );

  mhpq_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .item_value    (item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .removed_value (removed_value),
    .top_value     (top_value),
    .entry_count   (entry_count),
    .status        (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous item still in progress");

  a_refused_delete_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == '0 && removed_value == '0)
    else $error("refused delete reports a nonempty heap or a removed value");

  a_insert_no_removed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> removed_value == '0)
    else $error("refused insert reports a removed value");

endmodule

`default_nettype wire
